// File: sv/epv_pkg.sv
// shared types and constants for the encoder period velocity block
package epv_pkg;

    // input item kinds carried on s_tuser
    typedef enum logic [1:0] {
        ACT_CAPTURE = 2'd0,
        ACT_READ    = 2'd1,
        ACT_DUTY    = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    // configuration register indexes
    typedef enum logic {
        CFG_CLOCK_HZ    = 1'b0,
        CFG_TICKS_REV   = 1'b1
    } cfg_index_t;

    localparam int unsigned TIME_W     = 32;
    localparam int unsigned TICKS_W    = 16;
    localparam int unsigned DUTY_W     = 11;
    localparam int unsigned DRIVE_W    = 10;
    localparam int unsigned VEL_W      = 32;
    localparam int unsigned NUM_W      = 42;
    localparam int unsigned DEN_W      = TIME_W + TICKS_W;
    localparam int unsigned CNT_W      = 6;
    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned OUT_DATA_W = 56;

    localparam logic [TIME_W-1:0]  CLOCK_HZ_RESET  = 32'd80000000;
    localparam logic [TICKS_W-1:0] TICKS_REV_RESET = 16'(10 * 63);
    localparam logic [9:0]         MILLI_SCALE     = 10'd1000;
    localparam logic signed [DUTY_W-1:0] DUTY_FULL =  11'sd1000;
    localparam logic signed [DUTY_W-1:0] DUTY_MIN  = -11'sd1000;
    localparam logic [CNT_W-1:0]   DIV_LAST        = CNT_W'(NUM_W - 1);

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic mul_load;
        logic div_step;
        logic out_load;
    } epv_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic in_read;
        logic div_zero;
        logic div_last;
        logic out_free;
    } epv_sts_t;

endpackage

// File: sv/epv_ctrl.sv
// controller state machine sequencing item handling and the divider
module epv_ctrl import epv_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  epv_sts_t sts,
    output epv_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MUL   = 4'b0010,
        ST_DIV   = 4'b0100,
        ST_WRITE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = sts.in_read ? ST_MUL : ST_WRITE;
                end
            end
            ST_MUL: begin
                state_next = sts.div_zero ? ST_WRITE : ST_DIV;
            end
            ST_DIV: begin
                if (sts.div_last) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // commands
    assign s_tready     = (state_reg == ST_IDLE);
    assign cmd.accept   = s_tready && s_tvalid;
    assign cmd.mul_load = (state_reg == ST_MUL);
    assign cmd.div_step = (state_reg == ST_DIV);
    assign cmd.out_load = (state_reg == ST_WRITE) && sts.out_free;

endmodule

// File: sv/epv_dp.sv
// datapath: encoder state, configuration, shift-subtract divider, result register
module epv_dp import epv_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [1:0]            s_tuser,
    input  logic                  cfg_valid,
    input  logic                  cfg_index,
    input  logic [TIME_W-1:0]     cfg_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  epv_cmd_t              cmd,
    output epv_sts_t              sts
);

    // input item fields
    action_t                   in_action;
    logic [TIME_W-1:0]         in_capture;
    logic                      in_b_rising;
    logic signed [DUTY_W-1:0]  in_duty;
    logic signed [DUTY_W-1:0]  duty_clamped;

    assign in_action   = action_t'(s_tuser);
    assign in_capture  = s_tdata[31:0];
    assign in_b_rising = s_tdata[32];
    assign in_duty     = s_tdata[43:33];

    logic [TIME_W-1:0]        clock_hz_reg;
    logic [TICKS_W-1:0]       ticks_reg;
    logic [TIME_W-1:0]        last_capture_reg;
    logic [TIME_W-1:0]        period_reg, period_next;
    logic [TIME_W-1:0]        period_read_reg;
    logic signed [DUTY_W-1:0] duty_reg;
    logic                     is_read_reg;
    logic                     zero_reg;
    logic                     neg_reg;
    logic [NUM_W-1:0]         quot_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [DEN_W-1:0]         rem_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     m_tvalid_reg;
    logic [OUT_DATA_W-1:0]    m_tdata_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_reg <= CLOCK_HZ_RESET;
            ticks_reg    <= TICKS_REV_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CLOCK_HZ:  clock_hz_reg <= cfg_data;
                CFG_TICKS_REV: ticks_reg    <= cfg_data[TICKS_W-1:0];
                default:       clock_hz_reg <= clock_hz_reg;
            endcase
        end
    end

    // duty clamp to full scale
    always_comb begin
        priority if (in_duty > DUTY_FULL) begin
            duty_clamped = DUTY_FULL;
        end else if (in_duty < DUTY_MIN) begin
            duty_clamped = DUTY_MIN;
        end else begin
            duty_clamped = in_duty;
        end
    end

    // period seen by a read, stale period dropped when the motor is off
    always_comb begin
        period_next = period_reg;
        if ((duty_reg == '0) && (period_read_reg == period_reg)) begin
            period_next = '0;
        end
    end

    // item state update at accept
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_capture_reg <= '0;
            period_reg       <= '0;
            period_read_reg  <= '0;
            duty_reg         <= '0;
            is_read_reg      <= 1'b0;
        end else if (cmd.accept) begin
            is_read_reg <= (in_action == ACT_READ);
            unique case (in_action)
                ACT_CAPTURE: begin
                    period_reg       <= in_b_rising ? (in_capture - last_capture_reg)
                                                    : (last_capture_reg - in_capture);
                    last_capture_reg <= in_capture;
                end
                ACT_READ: begin
                    period_reg      <= period_next;
                    period_read_reg <= period_next;
                end
                ACT_DUTY: begin
                    duty_reg <= duty_clamped;
                end
                ACT_NONE: begin
                    duty_reg <= duty_reg;
                end
                default: begin
                    duty_reg <= duty_reg;
                end
            endcase
        end
    end

    // period magnitude and the two products
    logic [TIME_W-1:0] period_mag;
    logic [DEN_W-1:0]  den_prod;
    logic [NUM_W-1:0]  num_prod;

    assign period_mag = period_reg[TIME_W-1] ? (TIME_W'(0) - period_reg) : period_reg;
    assign den_prod   = period_mag * ticks_reg;
    assign num_prod   = clock_hz_reg * MILLI_SCALE;

    // one divider step: shift in the next dividend bit, subtract when it fits
    logic [DEN_W:0] trial;
    logic           fits;

    assign trial = {rem_reg, quot_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    // divider registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            zero_reg <= 1'b0;
        end else if (cmd.mul_load) begin
            cnt_reg  <= '0;
            zero_reg <= (period_reg == '0) || (ticks_reg == '0);
        end else if (cmd.div_step) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_load) begin
            den_reg  <= den_prod;
            quot_reg <= num_prod;
            rem_reg  <= '0;
            neg_reg  <= period_reg[TIME_W-1];
        end else if (cmd.div_step) begin
            rem_reg  <= fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            quot_reg <= {quot_reg[NUM_W-2:0], fits};
        end
    end

    // saturate and sign the quotient
    logic [VEL_W-1:0] vel_sat;
    logic [VEL_W-1:0] vel_word;

    always_comb begin
        if (neg_reg) begin
            vel_sat = (quot_reg > NUM_W'(32'h8000_0000)) ? 32'h8000_0000
                                                        : quot_reg[VEL_W-1:0];
            vel_word = VEL_W'(0) - vel_sat;
        end else begin
            vel_sat = (quot_reg > NUM_W'(32'h7fff_ffff)) ? 32'h7fff_ffff
                                                        : quot_reg[VEL_W-1:0];
            vel_word = vel_sat;
        end
    end

    // drive magnitudes from the held duty
    logic [DRIVE_W-1:0] drive_a;
    logic [DRIVE_W-1:0] drive_b;
    logic [VEL_W-1:0]   vel_out;

    assign drive_a = duty_reg[DUTY_W-1] ? DRIVE_W'(-duty_reg) : '0;
    assign drive_b = (!duty_reg[DUTY_W-1] && (duty_reg != '0)) ? duty_reg[DRIVE_W-1:0] : '0;
    assign vel_out = (is_read_reg && !zero_reg) ? vel_word : '0;

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {4'd0, drive_b, drive_a, vel_out};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // status
    assign sts.in_read  = (in_action == ACT_READ);
    assign sts.div_zero = (period_reg == '0) || (ticks_reg == '0);
    assign sts.div_last = (cnt_reg == DIV_LAST);
    assign sts.out_free = !m_tvalid_reg || m_tready;

endmodule

// File: sv/encoder_period_velocity.sv
// top level of the quadrature encoder period velocity estimator
//
// channel  direction  handshake              payload
// s_       in         s_tvalid / s_tready    s_tdata, s_tuser (item kind)
// m_       out        m_tvalid / m_tready    m_tdata
// cfg_     in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// capture, set-duty and unused items go from accept straight to the result load
// a velocity read takes one product step, then the one-bit-per-cycle
// shift-subtract divider, then the result load
// a read with zero period or zero ticks per turn skips the divider and gives zero velocity
// one item is handled at a time; the next is accepted while the result waits,
// and its own result load stalls until the waiting result is taken
// aresetn is synchronous, active low; it restores the register defaults
module encoder_period_velocity import epv_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // capture_time [31:0], b_rising [32], duty_permille [43:33], zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // action [1:0]
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // velocity_mrps [31:0], drive_a [41:32], drive_b [51:42], zero fill
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [TIME_W-1:0]     cfg_data
);

    epv_cmd_t cmd;
    epv_sts_t sts;

    // configuration is taken whenever offered
    assign cfg_ready = 1'b1;

    // controller
    epv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    epv_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
